// ===== design/cpcf_pkg.sv =====
// -----------------------------------------------------------------------------
// cpcf_pkg
// Shared types, constants and frame table of the camera periodic frame unit.
// -----------------------------------------------------------------------------
package cpcf_pkg;

	localparam int TICK_W    = 16;
	localparam int ID_W      = 11;
	localparam int LEN_W     = 4;
	localparam int WORD_W    = 32;
	localparam int NUM_FRAMES = 13;
	localparam int IDX_W     = $clog2(NUM_FRAMES);
	localparam int DIV_W     = TICK_W;
	localparam int DVSR_W    = 4;
	localparam int Q5_W      = 14;   // 65535 / 5 < 2**14
	localparam int Q100_W    = 10;   // 65535 / 100 < 2**10

	// reciprocals scaled by 2**RECIP_SHIFT, exact for any 16-bit dividend
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 20;
	localparam int PROD_W      = DIV_W + RECIP_W;

	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_FRAMES - 1);
	localparam logic [DVSR_W-1:0] DVSR_5   = DVSR_W'(5);
	localparam logic [DVSR_W-1:0] DVSR_7   = DVSR_W'(7);
	localparam logic [DVSR_W-1:0] DVSR_15  = DVSR_W'(15);

	localparam logic [RECIP_W-1:0] RECIP_5  = 18'd209716;
	localparam logic [RECIP_W-1:0] RECIP_7  = 18'd149797;
	localparam logic [RECIP_W-1:0] RECIP_15 = 18'd69906;

	localparam logic [ID_W-1:0] ID_STAT_A = 11'h489;
	localparam logic [ID_W-1:0] ID_STAT_B = 11'h48A;

	typedef enum logic [1:0] {
		PER_5,
		PER_40,
		PER_100
	} period_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV5,
		ST_DIV7,
		ST_DIV20,
		ST_DIV15,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic              bus;
		logic [LEN_W-1:0]  len;
		period_t           period;
		logic [WORD_W-1:0] head;
		logic [WORD_W-1:0] tail;
	} frame_entry_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DVSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_W-1:0]  quotient;
		logic [DVSR_W-1:0] remainder;
	} div_rsp_t;

	localparam frame_entry_t FRAME_TABLE [NUM_FRAMES] = '{
		'{11'h367, 1'b0, 4'd2, PER_40,  32'h0600_0000, 32'h0000_0000},
		'{11'h414, 1'b0, 4'd8, PER_100, 32'h0000_0000, 32'h0000_1700},
		'{11'h489, 1'b0, 4'd8, PER_100, 32'h0000_0000, 32'h0000_0000},
		'{11'h48A, 1'b0, 4'd8, PER_100, 32'h0000_0000, 32'h0000_0000},
		'{11'h48B, 1'b0, 4'd8, PER_100, 32'h6606_080A, 32'h0200_0000},
		'{11'h4D3, 1'b0, 4'd8, PER_100, 32'h1C00_0001, 32'h0000_0000},
		'{11'h130, 1'b1, 4'd7, PER_100, 32'h0000_0000, 32'h0000_3800},
		'{11'h240, 1'b1, 4'd8, PER_5,   32'h0000_1001, 32'h0010_0100},
		'{11'h241, 1'b1, 4'd8, PER_5,   32'h0000_1001, 32'h0010_0100},
		'{11'h244, 1'b1, 4'd8, PER_5,   32'h0000_1001, 32'h0010_0100},
		'{11'h245, 1'b1, 4'd8, PER_5,   32'h0000_1001, 32'h0010_0100},
		'{11'h248, 1'b1, 4'd8, PER_5,   32'h0000_0000, 32'h0000_0001},
		'{11'h466, 1'b1, 4'd3, PER_100, 32'h2020_AD00, 32'h0000_0000}
	};

endpackage

// ===== design/cpcf_if.sv =====
// -----------------------------------------------------------------------------
// cpcf_if
// Valid/ready channels: scheduling tick in, CAN frame out.
// -----------------------------------------------------------------------------
interface cpcf_tick_if;
	logic                         valid;
	logic                         ready;
	logic [cpcf_pkg::TICK_W-1:0]  tick_count;

	modport source (output valid, output tick_count, input ready);
	modport sink   (input valid, input tick_count, output ready);
endinterface

interface cpcf_frame_if;
	logic                         valid;
	logic                         ready;
	logic [cpcf_pkg::ID_W-1:0]    frame_id;
	logic                         target_bus;
	logic [cpcf_pkg::LEN_W-1:0]   byte_count;
	logic [cpcf_pkg::WORD_W-1:0]  payload_head;
	logic [cpcf_pkg::WORD_W-1:0]  payload_tail;
	logic                         last_frame;

	modport source (output valid, output frame_id, output target_bus, output byte_count,
		output payload_head, output payload_tail, output last_frame, input ready);
	modport sink   (input valid, input frame_id, input target_bus, input byte_count,
		input payload_head, input payload_tail, input last_frame, output ready);
endinterface

// ===== design/cpcf_div.sv =====
// -----------------------------------------------------------------------------
// cpcf_div
// Shared divider by a small constant: reciprocal multiply for the quotient,
// then multiply back and subtract for the remainder, one request at a time.
// -----------------------------------------------------------------------------
module cpcf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  cpcf_pkg::div_req_t req,
	output cpcf_pkg::div_rsp_t rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [cpcf_pkg::DIV_W-1:0]          num_q;
	logic [cpcf_pkg::DIV_W-1:0]          quot_q;
	logic [cpcf_pkg::DVSR_W-1:0]         rem_q;
	logic [cpcf_pkg::DVSR_W-1:0]         dvsr_q;

	logic [cpcf_pkg::RECIP_W-1:0]        recip;
	logic [cpcf_pkg::PROD_W-1:0]         prod;
	logic [cpcf_pkg::DIV_W-1:0]          back;

	always_comb begin
		case (req.divisor)
			cpcf_pkg::DVSR_5:  recip = cpcf_pkg::RECIP_5;
			cpcf_pkg::DVSR_7:  recip = cpcf_pkg::RECIP_7;
			cpcf_pkg::DVSR_15: recip = cpcf_pkg::RECIP_15;
			default:           recip = '0;
		endcase
	end

	assign prod = cpcf_pkg::PROD_W'(req.dividend) * cpcf_pkg::PROD_W'(recip);
	assign back = quot_q * cpcf_pkg::DIV_W'(dvsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= req.start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.dividend;
			quot_q <= cpcf_pkg::DIV_W'(prod >> cpcf_pkg::RECIP_SHIFT);
			dvsr_q <= req.divisor;
		end
		if (busy_q)
			rem_q <= cpcf_pkg::DVSR_W'(num_q - back);
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quot_q;
	assign rsp.remainder = rem_q;

	a_rem_below_dvsr: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dvsr_q)
		else $error("divider remainder not below divisor");

	a_no_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("divider started while busy");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> done_q)
		else $error("divider did not finish after its second cycle");

	a_quot_exact: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (quot_q * cpcf_pkg::DIV_W'(dvsr_q) + cpcf_pkg::DIV_W'(rem_q)) == num_q)
		else $error("divider quotient and remainder do not rebuild the dividend");

endmodule

// ===== design/camera_periodic_can_frames_unit.sv =====
// Sequence: a tick beat is accepted in idle, then four divisions (by 5, 7, 5 and
//   15) run one after another, then the table is walked in order; stalls hold it.
// A new tick is taken only once the walk for the previous one is through.
// A tick with nothing due emits no beat. Output register holds one frame.
// Reset (arst_n low, asynchronous): sequencer idle, no frame pending.
// -----------------------------------------------------------------------------
// camera_periodic_can_frames_unit
// Emits the camera CAN frames due on each scheduling tick, in table order.
// -----------------------------------------------------------------------------
module camera_periodic_can_frames_unit (
	input  logic                clk,
	input  logic                arst_n,
	cpcf_tick_if.sink           tick,
	cpcf_frame_if.source        frame
);

	cpcf_pkg::seq_state_t state_q, state_d;
	cpcf_pkg::div_req_t   div_req;
	cpcf_pkg::div_rsp_t   div_rsp;

	logic [cpcf_pkg::Q5_W-1:0]    q5_q;
	logic                         r5_zero_q;
	logic [2:0]                   r7_q;
	logic                         r20_zero_q;
	logic [cpcf_pkg::DVSR_W-1:0]  r15_q;
	logic [cpcf_pkg::IDX_W-1:0]   idx_q;

	logic                               out_valid_q;
	logic [cpcf_pkg::ID_W-1:0]          id_q;
	logic                               bus_q;
	logic [cpcf_pkg::LEN_W-1:0]         len_q;
	logic [cpcf_pkg::WORD_W-1:0]        head_q;
	logic [cpcf_pkg::WORD_W-1:0]        tail_q;
	logic                               last_q;

	logic [cpcf_pkg::NUM_FRAMES-1:0]    due_vec;
	logic                               cur_due;
	logic                               last_c;
	logic                               can_load;
	logic                               load_out;
	logic                               advance;
	cpcf_pkg::frame_entry_t             ent;
	logic [cpcf_pkg::WORD_W-1:0]        head_c;
	logic [cpcf_pkg::WORD_W-1:0]        tail_c;

	cpcf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// divisible by 40: by 5 and quotient by 8; by 100: by 5, q5 by 4, q5/4 by 5
	always_comb begin
		for (int i = 0; i < cpcf_pkg::NUM_FRAMES; i++) begin
			case (cpcf_pkg::FRAME_TABLE[i].period)
				cpcf_pkg::PER_5:   due_vec[i] = r5_zero_q;
				cpcf_pkg::PER_40:  due_vec[i] = r5_zero_q && (q5_q[2:0] == 3'd0);
				cpcf_pkg::PER_100: due_vec[i] = r5_zero_q && (q5_q[1:0] == 2'd0)
				                              && r20_zero_q;
				default:           due_vec[i] = 1'b0;
			endcase
		end
	end

	always_comb begin
		last_c = 1'b1;
		for (int j = 0; j < cpcf_pkg::NUM_FRAMES; j++) begin
			if (cpcf_pkg::IDX_W'(j) > idx_q && due_vec[j])
				last_c = 1'b0;
		end
	end

	assign cur_due  = due_vec[idx_q];
	assign can_load = !out_valid_q || frame.ready;

	// payload with the rolling bytes patched in
	always_comb begin
		ent    = cpcf_pkg::FRAME_TABLE[idx_q];
		head_c = ent.head;
		tail_c = ent.tail;
		if (ent.period == cpcf_pkg::PER_5) begin
			head_c[31:24] = {3'(r7_q + 3'd1), 5'd0};
		end else if (ent.id == cpcf_pkg::ID_STAT_A || ent.id == cpcf_pkg::ID_STAT_B) begin
			tail_c[7:0] = {ent.id[1], 3'd0, 4'(r15_q + 4'd1)};
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cpcf_pkg::ST_IDLE:  if (tick.valid) state_d = cpcf_pkg::ST_DIV5;
			cpcf_pkg::ST_DIV5:  if (div_rsp.done) state_d = cpcf_pkg::ST_DIV7;
			cpcf_pkg::ST_DIV7:  if (div_rsp.done) state_d = cpcf_pkg::ST_DIV20;
			cpcf_pkg::ST_DIV20: if (div_rsp.done) state_d = cpcf_pkg::ST_DIV15;
			cpcf_pkg::ST_DIV15: if (div_rsp.done) state_d = cpcf_pkg::ST_EMIT;
			cpcf_pkg::ST_EMIT:  if (advance && idx_q == cpcf_pkg::LAST_IDX)
				state_d = cpcf_pkg::ST_IDLE;
			default:            state_d = cpcf_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs; each division is started as the previous one finishes
	always_comb begin
		tick.ready       = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = cpcf_pkg::DVSR_5;
		load_out         = 1'b0;
		advance          = 1'b0;
		case (state_q)
			cpcf_pkg::ST_IDLE: begin
				tick.ready       = 1'b1;
				div_req.start    = tick.valid;
				div_req.dividend = tick.tick_count;
				div_req.divisor  = cpcf_pkg::DVSR_5;
			end
			cpcf_pkg::ST_DIV5: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = cpcf_pkg::DIV_W'(div_rsp.quotient[cpcf_pkg::Q5_W-1:0]);
				div_req.divisor  = cpcf_pkg::DVSR_7;
			end
			cpcf_pkg::ST_DIV7: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = cpcf_pkg::DIV_W'(q5_q[cpcf_pkg::Q5_W-1:2]);
				div_req.divisor  = cpcf_pkg::DVSR_5;
			end
			cpcf_pkg::ST_DIV20: begin
				div_req.start    = div_rsp.done;
				div_req.dividend =
					cpcf_pkg::DIV_W'(div_rsp.quotient[cpcf_pkg::Q100_W-1:0]);
				div_req.divisor  = cpcf_pkg::DVSR_15;
			end
			cpcf_pkg::ST_DIV15: begin
			end
			cpcf_pkg::ST_EMIT: begin
				load_out = cur_due && can_load;
				advance  = !cur_due || can_load;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpcf_pkg::ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == cpcf_pkg::ST_DIV15)
				idx_q <= '0;
			else if (advance)
				idx_q <= idx_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (frame.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_rsp.done) begin
			case (state_q)
				cpcf_pkg::ST_DIV5: begin
					q5_q      <= div_rsp.quotient[cpcf_pkg::Q5_W-1:0];
					r5_zero_q <= (div_rsp.remainder == '0);
				end
				cpcf_pkg::ST_DIV7:  r7_q <= div_rsp.remainder[2:0];
				cpcf_pkg::ST_DIV20: r20_zero_q <= (div_rsp.remainder == '0);
				cpcf_pkg::ST_DIV15: r15_q <= div_rsp.remainder;
				default: begin
				end
			endcase
		end
		if (load_out) begin
			id_q   <= ent.id;
			bus_q  <= ent.bus;
			len_q  <= ent.len;
			head_q <= head_c;
			tail_q <= tail_c;
			last_q <= last_c;
		end
	end

	assign frame.valid        = out_valid_q;
	assign frame.frame_id     = id_q;
	assign frame.target_bus   = bus_q;
	assign frame.byte_count   = len_q;
	assign frame.payload_head = head_q;
	assign frame.payload_tail = tail_q;
	assign frame.last_frame   = last_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q != cpcf_pkg::ST_IDLE && state_q != cpcf_pkg::ST_EMIT))
		else $error("divider finished outside a division step");

	a_rolls_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cpcf_pkg::ST_EMIT |-> (r7_q <= 3'd6 && r15_q <= 4'd14))
		else $error("rolling counter remainder out of range");

	a_emit_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cpcf_pkg::ST_EMIT && advance && idx_q == cpcf_pkg::LAST_IDX)
		|=> state_q == cpcf_pkg::ST_IDLE)
		else $error("table walk did not end in idle");

	a_last_no_more: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && last_c) |=> !load_out)
		else $error("frame loaded after last frame of tick");

endmodule

// ===== tb/tb_camera_periodic_can_frames_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_camera_periodic_can_frames_unit
// Drives scheduling ticks into the camera frame unit and compares every emitted
// CAN frame with a local prediction of the frame table, under random idling on
// both channels.
// -----------------------------------------------------------------------------
module tb_camera_periodic_can_frames_unit;

	localparam int QUIET_LIMIT = 5000;
	localparam int RANDOM_TICKS = 310;
	localparam int CAM_FRAMES = 13;

	typedef struct {
		logic [cpcf_pkg::ID_W-1:0]   id;
		logic                        bus;
		logic [cpcf_pkg::LEN_W-1:0]  len;
		logic [cpcf_pkg::WORD_W-1:0] head;
		logic [cpcf_pkg::WORD_W-1:0] tail;
		logic                        last;
	} can_frame_t;

	// Camera frame schedule: id, bus, length, period, payload words
	localparam logic [cpcf_pkg::ID_W-1:0] SCHED_ID [CAM_FRAMES] = '{
		11'h367, 11'h414, 11'h489, 11'h48A, 11'h48B, 11'h4D3, 11'h130,
		11'h240, 11'h241, 11'h244, 11'h245, 11'h248, 11'h466};
	localparam logic SCHED_BUS [CAM_FRAMES] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
	localparam logic [cpcf_pkg::LEN_W-1:0] SCHED_LEN [CAM_FRAMES] = '{
		4'd2, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd3};
	localparam int SCHED_PERIOD [CAM_FRAMES] = '{
		40, 100, 100, 100, 100, 100, 100, 5, 5, 5, 5, 5, 100};
	localparam logic [cpcf_pkg::WORD_W-1:0] SCHED_HEAD [CAM_FRAMES] = '{
		32'h0600_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h6606_080A,
		32'h1C00_0001, 32'h0000_0000, 32'h0000_1001, 32'h0000_1001, 32'h0000_1001,
		32'h0000_1001, 32'h0000_0000, 32'h2020_AD00};
	localparam logic [cpcf_pkg::WORD_W-1:0] SCHED_TAIL [CAM_FRAMES] = '{
		32'h0000_0000, 32'h0000_1700, 32'h0000_0000, 32'h0000_0000, 32'h0200_0000,
		32'h0000_0000, 32'h0000_3800, 32'h0010_0100, 32'h0010_0100, 32'h0010_0100,
		32'h0010_0100, 32'h0000_0001, 32'h0000_0000};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cpcf_tick_if  tick_ch();
	cpcf_frame_if frame_ch();

	camera_periodic_can_frames_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.frame  (frame_ch)
	);

	logic [cpcf_pkg::TICK_W-1:0] tick_queue[$];
	can_frame_t        due_frames[$];
	int ticks_total;
	int ticks_sent;
	int frames_seen;
	int full_ticks;
	int empty_ticks;
	int errors;
	int tick_gap;
	int frame_stall;
	int quiet_cycles;
	bit calm_ticks;
	bit calm_frames;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_wait(bit calm);
		if (calm || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	// Frames due on one tick, appended in schedule order
	function automatic void predict_frames(logic [cpcf_pkg::TICK_W-1:0] count);
		can_frame_t batch[$];
		can_frame_t f;
		int c;
		logic [7:0] roll5;
		logic [7:0] roll100;
		c = count;
		roll5 = 8'((((c / 5) % 7) + 1) << 5);
		roll100 = 8'(((c / 100) % 15) + 1);
		for (int i = 0; i < CAM_FRAMES; i++) begin
			if (c % SCHED_PERIOD[i] != 0)
				continue;
			f.id = SCHED_ID[i];
			f.bus = SCHED_BUS[i];
			f.len = SCHED_LEN[i];
			f.head = SCHED_HEAD[i];
			f.tail = SCHED_TAIL[i];
			f.last = 1'b0;
			if (SCHED_PERIOD[i] == 5)
				f.head[31:24] = roll5;
			else if (f.id == cpcf_pkg::ID_STAT_A)
				f.tail[7:0] = roll100;
			else if (f.id == cpcf_pkg::ID_STAT_B)
				f.tail[7:0] = 8'h80 | roll100;
			batch.push_back(f);
		end
		if (batch.size() == 0) begin
			empty_ticks++;
		end else begin
			batch[batch.size() - 1].last = 1'b1;
			if (batch.size() == CAM_FRAMES)
				full_ticks++;
		end
		foreach (batch[k])
			due_frames.push_back(batch[k]);
	endfunction

	task automatic report_mismatch(string field, logic [cpcf_pkg::WORD_W-1:0] got,
		logic [cpcf_pkg::WORD_W-1:0] want);
		$display("MISMATCH frame %0d %s: got %h, expected %h", frames_seen, field, got, want);
		errors++;
	endtask

	// Tick driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
			tick_ch.tick_count <= '0;
			tick_gap = 0;
		end else begin
			if (tick_ch.valid && tick_ch.ready) begin
				predict_frames(tick_ch.tick_count);
				ticks_sent++;
				if ($urandom_range(0, 29) == 0)
					calm_ticks = !calm_ticks;
				tick_gap = draw_wait(calm_ticks);
			end
			if (!tick_ch.valid || tick_ch.ready) begin
				if (tick_gap > 0) begin
					tick_gap--;
					tick_ch.valid <= 1'b0;
				end else if (tick_queue.size() > 0) begin
					tick_ch.valid <= 1'b1;
					tick_ch.tick_count <= tick_queue.pop_front();
				end else begin
					tick_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Frame monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.ready <= 1'b0;
			frame_stall = 0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				if (due_frames.size() == 0) begin
					report_mismatch("unexpected frame_id", 32'(frame_ch.frame_id), '0);
				end else begin
					can_frame_t want;
					want = due_frames.pop_front();
					if (frame_ch.frame_id !== want.id)
						report_mismatch("frame_id", 32'(frame_ch.frame_id), 32'(want.id));
					if (frame_ch.target_bus !== want.bus)
						report_mismatch("target_bus", 32'(frame_ch.target_bus),
							32'(want.bus));
					if (frame_ch.byte_count !== want.len)
						report_mismatch("byte_count", 32'(frame_ch.byte_count),
							32'(want.len));
					if (frame_ch.payload_head !== want.head)
						report_mismatch("payload_head", frame_ch.payload_head, want.head);
					if (frame_ch.payload_tail !== want.tail)
						report_mismatch("payload_tail", frame_ch.payload_tail, want.tail);
					if (frame_ch.last_frame !== want.last)
						report_mismatch("last_frame", 32'(frame_ch.last_frame),
							32'(want.last));
				end
				frames_seen++;
				if ($urandom_range(0, 29) == 0)
					calm_frames = !calm_frames;
				frame_stall = draw_wait(calm_frames);
			end
			if (frame_stall > 0) begin
				frame_stall--;
				frame_ch.ready <= 1'b0;
			end else begin
				frame_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_ch.valid && tick_ch.ready) || (frame_ch.valid && frame_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("watchdog: %0d idle cycles, %0d frames still due",
						quiet_cycles, due_frames.size());
					$display("camera_periodic_can_frames_unit test failed");
					$finish;
				end
			end
		end
	end

	initial begin
		int pick;
		tick_ch.valid = 1'b0;
		tick_ch.tick_count = '0;
		frame_ch.ready = 1'b0;
		quiet_cycles = 0;
		calm_ticks = 1'b0;
		calm_frames = 1'b0;

		// directed: all due, nothing due, roll-over points of both counters, extremes
		tick_queue = '{16'd0, 16'd65535, 16'd1, 16'd5, 16'd35, 16'd40, 16'd100, 16'd200,
			16'd700, 16'd1400, 16'd1500, 16'd4000, 16'd6000, 16'd65500, 16'd65520,
			16'h5555, 16'hAAAA, 16'd3, 16'd120, 16'd65000, 16'd2, 16'd0};
		for (int n = 0; n < RANDOM_TICKS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				tick_queue.push_back(cpcf_pkg::TICK_W'($urandom_range(0, 655) * 100));
			else if (pick < 50)
				tick_queue.push_back(cpcf_pkg::TICK_W'($urandom_range(0, 1638) * 40));
			else if (pick < 75)
				tick_queue.push_back(cpcf_pkg::TICK_W'($urandom_range(0, 13107) * 5));
			else
				tick_queue.push_back(cpcf_pkg::TICK_W'($urandom()));
		end
		ticks_total = tick_queue.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (ticks_sent < ticks_total || due_frames.size() > 0)
			@(posedge clk);
		// room for a trailing tick that produces nothing, or a stray frame
		repeat (120) @(posedge clk);

		$display("Drove %0d ticks (%0d with every frame due, %0d with none due)",
			ticks_sent, full_ticks, empty_ticks);
		$display("Checked %0d frame beats, %0d mismatches", frames_seen, errors);
		if (errors == 0)
			$display("camera_periodic_can_frames_unit test passed");
		else
			$display("camera_periodic_can_frames_unit test failed");
		$finish;
	end

endmodule
